>>> rtl/core/sxt_pkg.sv
package sxt_pkg;

   localparam int DEFAULT_POS_WIDTH = 16;
   localparam int OUT_POS_WIDTH     = 16;
   localparam logic [OUT_POS_WIDTH-1:0] OUT_POS_MAX = '1;

   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   typedef enum logic [2:0] {
      ST_INITIAL = 3'd0,
      ST_COMMENT = 3'd1,
      ST_STRING  = 3'd2,
      ST_ESC     = 3'd3,
      ST_ATOM    = 3'd4
   } scan_state_type;

   typedef enum logic [2:0] {
      KIND_EOF    = 3'd0,
      KIND_ATOM   = 3'd1,
      KIND_STRING = 3'd2,
      KIND_LPAREN = 3'd3,
      KIND_RPAREN = 3'd4,
      KIND_DOT    = 3'd5
   } token_kind_type;

   typedef enum logic [1:0] {
      EV_VALUE    = 2'd0,
      EV_COMPLETE = 2'd1,
      EV_ERROR    = 2'd2
   } event_type;

   typedef struct packed {
      logic                     last;
      logic [OUT_POS_WIDTH-1:0] col;
      logic [OUT_POS_WIDTH-1:0] line;
      logic [7:0]               value_char;
      token_kind_type           token_kind;
      event_type                event_res;
   } result_type;

   typedef struct packed {
      result_type res0;
      result_type res1;
      logic [1:0] count;
   } step_type;

endpackage

>>> rtl/core/sxt_lexer.sv
module sxt_lexer #(
   parameter int POS_WIDTH = sxt_pkg::DEFAULT_POS_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  logic [7:0]        ch,
   input  logic              eoi,
   output sxt_pkg::step_type step
);
   import sxt_pkg::*;

   localparam logic [POS_WIDTH-1:0] POS_ONE  = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_SAT  = '1;
   localparam logic [POS_WIDTH-1:0] CLIP_LIM = POS_WIDTH'(OUT_POS_MAX);

   scan_state_type           state_ff, state_in;
   token_kind_type           open_ff, open_in;
   logic [POS_WIDTH-1:0]     line_ff, line_in, col_ff, col_in;
   logic [POS_WIDTH-1:0]     sline_ff, sline_in, scol_ff, scol_in;

   result_type               init_res;
   logic                     init_emit, init_start;
   scan_state_type           init_state;
   token_kind_type           init_open;
   logic                     is_space;
   logic [7:0]               up_ch;

   result_type               res0, res1;
   logic [1:0]               count;

   function automatic logic [OUT_POS_WIDTH-1:0] clip_pos(input logic [POS_WIDTH-1:0] v);
      return (v > CLIP_LIM) ? OUT_POS_MAX : OUT_POS_WIDTH'(v);
   endfunction

   function automatic result_type make_res(input event_type ev, input token_kind_type kind,
                                           input logic [7:0] vc,
                                           input logic [POS_WIDTH-1:0] ln,
                                           input logic [POS_WIDTH-1:0] cl);
      result_type r;
      r.last       = 1'b0;
      r.col        = clip_pos(cl);
      r.line       = clip_pos(ln);
      r.value_char = vc;
      r.token_kind = kind;
      r.event_res  = ev;
      return r;
   endfunction

   assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign up_ch    = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ? ch - CASE_DIFF : ch;

   // Outcome of a character seen outside any token.
   always_comb begin
      init_res   = make_res(EV_COMPLETE, KIND_EOF, 8'h00, line_ff, col_ff);
      init_emit  = 1'b0;
      init_start = 1'b0;
      init_state = ST_INITIAL;
      init_open  = KIND_EOF;
      case (ch)
         CH_SEMI: begin
            init_state = ST_COMMENT;
         end
         CH_QUOTE: begin
            init_state = ST_STRING;
            init_open  = KIND_STRING;
            init_start = 1'b1;
         end
         CH_LPAREN: begin
            init_emit = 1'b1;
            init_res  = make_res(EV_COMPLETE, KIND_LPAREN, 8'h00, line_ff, col_ff);
         end
         CH_RPAREN: begin
            init_emit = 1'b1;
            init_res  = make_res(EV_COMPLETE, KIND_RPAREN, 8'h00, line_ff, col_ff);
         end
         CH_DOT: begin
            init_emit = 1'b1;
            init_res  = make_res(EV_COMPLETE, KIND_DOT, 8'h00, line_ff, col_ff);
         end
         default: begin
            if (!is_space) begin
               init_state = ST_ATOM;
               init_open  = KIND_ATOM;
               init_start = 1'b1;
               init_emit  = 1'b1;
               init_res   = make_res(EV_VALUE, KIND_ATOM, up_ch, line_ff, col_ff);
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      open_in  = open_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      res0     = '0;
      res1     = '0;
      count    = 2'd0;
      if (eoi) begin
         if ((state_ff == ST_STRING) || (state_ff == ST_ESC)) begin
            res0  = make_res(EV_ERROR, open_ff, 8'h00, sline_ff, scol_ff);
            count = 2'd1;
         end else if (state_ff == ST_ATOM) begin
            res0  = make_res(EV_COMPLETE, open_ff, 8'h00, sline_ff, scol_ff);
            res1  = make_res(EV_COMPLETE, KIND_EOF, 8'h00, line_ff, col_ff);
            count = 2'd2;
         end else begin
            res0  = make_res(EV_COMPLETE, KIND_EOF, 8'h00, line_ff, col_ff);
            count = 2'd1;
         end
         state_in = ST_INITIAL;
         open_in  = KIND_EOF;
      end else begin
         if (ch == CH_NL) begin
            if (line_ff != POS_SAT) begin
               line_in = line_ff + POS_ONE;
            end
            col_in = POS_ONE;
         end else if (col_ff != POS_SAT) begin
            col_in = col_ff + POS_ONE;
         end

         unique case (state_ff)
            ST_COMMENT: begin
               if (ch == CH_NL) begin
                  state_in = ST_INITIAL;
               end
            end
            ST_STRING: begin
               if (ch == CH_BSLASH) begin
                  state_in = ST_ESC;
               end else if (ch == CH_QUOTE) begin
                  res0     = make_res(EV_COMPLETE, open_ff, 8'h00, sline_ff, scol_ff);
                  count    = 2'd1;
                  state_in = ST_INITIAL;
                  open_in  = KIND_EOF;
               end else begin
                  res0  = make_res(EV_VALUE, open_ff, ch, sline_ff, scol_ff);
                  count = 2'd1;
               end
            end
            ST_ESC: begin
               if (ch == CH_LOWER_N) begin
                  res0  = make_res(EV_VALUE, open_ff, CH_NL, sline_ff, scol_ff);
                  count = 2'd1;
               end else if (ch == CH_LOWER_T) begin
                  res0  = make_res(EV_VALUE, open_ff, CH_TAB, sline_ff, scol_ff);
                  count = 2'd1;
               end else if (ch != CH_NL) begin
                  res0  = make_res(EV_VALUE, open_ff, ch, sline_ff, scol_ff);
                  count = 2'd1;
               end
               state_in = ST_STRING;
            end
            ST_ATOM: begin
               if ((ch == CH_SEMI) || (ch == CH_QUOTE) ||
                   (ch == CH_LPAREN) || (ch == CH_RPAREN)) begin
                  res0     = make_res(EV_COMPLETE, open_ff, 8'h00, sline_ff, scol_ff);
                  res1     = init_res;
                  count    = init_emit ? 2'd2 : 2'd1;
                  state_in = init_state;
                  open_in  = init_open;
                  if (init_start) begin
                     sline_in = line_ff;
                     scol_in  = col_ff;
                  end
               end else if (is_space) begin
                  res0     = make_res(EV_COMPLETE, open_ff, 8'h00, sline_ff, scol_ff);
                  count    = 2'd1;
                  state_in = ST_INITIAL;
                  open_in  = KIND_EOF;
               end else begin
                  res0  = make_res(EV_VALUE, open_ff, up_ch, sline_ff, scol_ff);
                  count = 2'd1;
               end
            end
            default: begin
               res0     = init_res;
               count    = init_emit ? 2'd1 : 2'd0;
               state_in = init_state;
               open_in  = init_open;
               if (init_start) begin
                  sline_in = line_ff;
                  scol_in  = col_ff;
               end
            end
         endcase
      end

      if (count == 2'd2) begin
         res1.last = 1'b1;
      end else if (count == 2'd1) begin
         res0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INITIAL;
         open_ff  <= KIND_EOF;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         sline_ff <= POS_ONE;
         scol_ff  <= POS_ONE;
      end else if (valid) begin
         state_ff <= state_in;
         open_ff  <= open_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
      end
   end

   assign step.res0  = res0;
   assign step.res1  = res1;
   assign step.count = count;

   a_eoi_to_initial: assert property (@(posedge clock) disable iff (reset)
      (valid && eoi) |=> (state_ff == ST_INITIAL))
      else $error("Scan state is not initial after end of input.");

   a_string_open_kind: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_STRING) || (state_ff == ST_ESC)) |-> (open_ff == KIND_STRING))
      else $error("Open token kind does not match string state.");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (count == 2'd2) |-> (res1.last && !res0.last))
      else $error("Last flag is not on the final result of a pair.");

endmodule

>>> rtl/core/sxt_out_buffer.sv
module sxt_out_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sxt_pkg::step_type   step,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output sxt_pkg::result_type rsp_res
);
   import sxt_pkg::*;

   result_type slot0_ff, slot1_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign rsp_res    = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load && (step.count != 2'd0)) begin
         count_ff <= step.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && (step.count != 2'd0)) begin
         slot0_ff <= step.res0;
         slot1_ff <= step.res1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Result buffer holds more than two results.");

   a_pair_drains: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd2) && pop) |=> (count_ff == 2'd1))
      else $error("Result buffer refilled before the pair drained.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (load && (step.count != 2'd0)) |=> (rsp_tvalid && (rsp_res == $past(step.res0))))
      else $error("Loaded result is not presented first.");

endmodule

>>> rtl/core/sexpr_tokenizer.sv
// S-expression tokenizer. Each input transfer carries one source byte, or an end-of-input
// mark in req_tuser. Value characters of atoms (upper-cased) and strings (escapes translated)
// are sent as they arrive, followed by a token-complete result; parens, dot and end of input
// give token-complete results of their own, and end of input inside a string gives an error.
// Every result carries the start line and column of its token, and rsp_tlast marks the final
// result caused by one input. An input is taken only when the two-slot result buffer is empty
// or its last result is being taken, and the buffer drains one result per cycle while
// rsp_tready is high; an input that causes two (a paren ending an atom, or end of input inside
// an atom) holds off the next one. Inputs are registered before the lexer. POS_WIDTH sets the
// line and column counters, which saturate; the reported positions saturate at 65535.
module sexpr_tokenizer #(
   parameter int POS_WIDTH = sxt_pkg::DEFAULT_POS_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] ch
   input  logic        req_tuser,  // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [1:0] event_res, [4:2] token_kind, [12:5] value_char,
                                   // [28:13] line, [44:29] col, [47:45] zero
   output logic        rsp_tlast   // last
);
   import sxt_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_eoi_ff;
   logic       can_load;
   logic       consume;
   step_type   step;
   result_type rsp_res;

   assign consume    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_eoi_ff <= req_tuser;
      end
   end

   sxt_lexer #(
      .POS_WIDTH(POS_WIDTH)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .valid(consume),
      .ch   (in_ch_ff),
      .eoi  (in_eoi_ff),
      .step (step)
   );

   sxt_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (consume),
      .step      (step),
      .can_load  (can_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_res   (rsp_res)
   );

   assign rsp_tdata = {3'b000, rsp_res.col, rsp_res.line, rsp_res.value_char,
                       rsp_res.token_kind, rsp_res.event_res};
   assign rsp_tlast = rsp_res.last;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sxt_pkg::*;

   localparam int POS_W           = DEFAULT_POS_WIDTH;
   localparam int POS_LIMIT       = (1 << POS_W) - 1;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int RX_HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES    = 6;
   localparam int MAX_PRINTED     = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   scan_state_type lex_state = ST_INITIAL;
   int             line_pos  = 1;
   int             col_pos   = 1;
   int             tok_line  = 1;
   int             tok_col   = 1;
   result_type     step_tokens[$];
   result_type     pending_tokens[$];

   int   mismatch_count = 0;
   int   result_count   = 0;
   int   items_sent     = 0;
   int   send_idle_pct  = 0;
   int   stall_pct      = 0;
   logic hold_go        = 1'b0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;

   sexpr_tokenizer #(
      .POS_WIDTH(POS_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] clip_pos(int v);
      return (v > int'(OUT_POS_MAX)) ? OUT_POS_MAX : v[15:0];
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_delimiter(logic [7:0] c);
      return c == CH_SEMI || c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   function automatic logic [7:0] upper_case(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DIFF : c;
   endfunction

   function automatic void add_token(event_type ev, token_kind_type kind, logic [7:0] vc,
                                     int ln, int cl);
      result_type r;
      r.event_res  = ev;
      r.token_kind = kind;
      r.value_char = vc;
      r.line       = clip_pos(ln);
      r.col        = clip_pos(cl);
      r.last       = 1'b0;
      step_tokens.push_back(r);
   endfunction

   function automatic void open_token(logic [7:0] c, int ln, int cl);
      if (c == CH_SEMI) begin
         lex_state = ST_COMMENT;
      end else if (c == CH_QUOTE) begin
         lex_state = ST_STRING;
         tok_line  = ln;
         tok_col   = cl;
      end else if (c == CH_LPAREN) begin
         add_token(EV_COMPLETE, KIND_LPAREN, 8'h00, ln, cl);
      end else if (c == CH_RPAREN) begin
         add_token(EV_COMPLETE, KIND_RPAREN, 8'h00, ln, cl);
      end else if (c == CH_DOT) begin
         add_token(EV_COMPLETE, KIND_DOT, 8'h00, ln, cl);
      end else if (!is_blank(c)) begin
         lex_state = ST_ATOM;
         tok_line  = ln;
         tok_col   = cl;
         add_token(EV_VALUE, KIND_ATOM, upper_case(c), ln, cl);
      end
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic eoi);
      int ln;
      int cl;
      ln = line_pos;
      cl = col_pos;
      step_tokens.delete();
      if (eoi) begin
         if (lex_state == ST_STRING || lex_state == ST_ESC) begin
            add_token(EV_ERROR, KIND_STRING, 8'h00, tok_line, tok_col);
         end else begin
            if (lex_state == ST_ATOM)
               add_token(EV_COMPLETE, KIND_ATOM, 8'h00, tok_line, tok_col);
            add_token(EV_COMPLETE, KIND_EOF, 8'h00, ln, cl);
         end
         lex_state = ST_INITIAL;
      end else begin
         if (c == CH_NL) begin
            if (line_pos < POS_LIMIT)
               line_pos++;
            col_pos = 1;
         end else if (col_pos < POS_LIMIT) begin
            col_pos++;
         end
         case (lex_state)
            ST_COMMENT: begin
               if (c == CH_NL)
                  lex_state = ST_INITIAL;
            end
            ST_STRING: begin
               if (c == CH_BSLASH) begin
                  lex_state = ST_ESC;
               end else if (c == CH_QUOTE) begin
                  add_token(EV_COMPLETE, KIND_STRING, 8'h00, tok_line, tok_col);
                  lex_state = ST_INITIAL;
               end else begin
                  add_token(EV_VALUE, KIND_STRING, c, tok_line, tok_col);
               end
            end
            ST_ESC: begin
               if (c == CH_LOWER_N)
                  add_token(EV_VALUE, KIND_STRING, CH_NL, tok_line, tok_col);
               else if (c == CH_LOWER_T)
                  add_token(EV_VALUE, KIND_STRING, CH_TAB, tok_line, tok_col);
               else if (c != CH_NL)
                  add_token(EV_VALUE, KIND_STRING, c, tok_line, tok_col);
               lex_state = ST_STRING;
            end
            ST_ATOM: begin
               if (is_delimiter(c)) begin
                  add_token(EV_COMPLETE, KIND_ATOM, 8'h00, tok_line, tok_col);
                  lex_state = ST_INITIAL;
                  open_token(c, ln, cl);
               end else if (is_blank(c)) begin
                  add_token(EV_COMPLETE, KIND_ATOM, 8'h00, tok_line, tok_col);
                  lex_state = ST_INITIAL;
               end else begin
                  add_token(EV_VALUE, KIND_ATOM, upper_case(c), tok_line, tok_col);
               end
            end
            default: begin
               lex_state = ST_INITIAL;
               open_token(c, ln, cl);
            end
         endcase
      end
      if (step_tokens.size() != 0)
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i])
         pending_tokens.push_back(step_tokens[i]);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   result_count, name, got, want));
   endtask

   task automatic send_item(logic [7:0] c, logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      tokenize_byte(c, eoi);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_text(string s);
      foreach (s[i])
         send_item(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_blank();
      return ($urandom_range(3) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(4));
   endfunction

   function automatic logic [7:0] random_atom_byte();
      logic [7:0] c;
      do begin
         if ($urandom_range(1) == 0)
            c = 8'($urandom_range(255));
         else if ($urandom_range(1) == 0)
            c = CH_LOWER_A + 8'($urandom_range(25));
         else
            c = CH_LOWER_A - CASE_DIFF + 8'($urandom_range(25));
      end while (is_delimiter(c) || is_blank(c));
      return c;
   endfunction

   function automatic logic [7:0] random_string_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   task automatic send_random_text(int count);
      int         start;
      int         len;
      int         pick;
      logic [7:0] c;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            len = $urandom_range(1, 6);
            repeat (len) send_item(random_atom_byte(), 1'b0);
         end else if (pick < 45) begin
            send_item(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len) begin
               if ($urandom_range(3) == 0) begin
                  send_item(CH_BSLASH, 1'b0);
                  case ($urandom_range(5))
                     0: send_item(CH_LOWER_N, 1'b0);
                     1: send_item(CH_LOWER_T, 1'b0);
                     2: send_item(CH_NL, 1'b0);
                     3: send_item(CH_BSLASH, 1'b0);
                     4: send_item(CH_QUOTE, 1'b0);
                     default: send_item(8'($urandom_range(255)), 1'b0);
                  endcase
               end else begin
                  send_item(random_string_byte(), 1'b0);
               end
            end
            if ($urandom_range(9) != 0)
               send_item(CH_QUOTE, 1'b0);
         end else if (pick < 60) begin
            case ($urandom_range(2))
               0: send_item(CH_LPAREN, 1'b0);
               1: send_item(CH_RPAREN, 1'b0);
               default: send_item(CH_DOT, 1'b0);
            endcase
         end else if (pick < 66) begin
            send_item(CH_SEMI, 1'b0);
            repeat ($urandom_range(0, 5)) begin
               c = 8'($urandom_range(255));
               send_item((c == CH_NL) ? CH_SPACE : c, 1'b0);
            end
            send_item(CH_NL, 1'b0);
         end else if (pick < 80) begin
            send_item(random_blank(), 1'b0);
         end else if (pick < 84) begin
            send_item(8'($urandom_range(255)), 1'b1);
         end else begin
            send_item(8'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   // Covers each atom end but ';', escapes, the dot token and end of input in each state.
   task automatic test_directed_tokens();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_text("a(z) . `{. ;x\n");
      send_text("\"q\\n\\t\\\n\\\"");
      send_item(8'hFF, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(CH_BSLASH, 1'b0);
      send_item(8'h00, 1'b1);
      send_text("x");
      send_item(8'h00, 1'b1);
      send_text(";");
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_tokens();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random_text(150);
      wait_drained();
      send_idle_pct = 66;
      stall_pct     = 0;
      send_random_text(150);
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 66;
      send_random_text(150);
      wait_drained();
      send_idle_pct = 14;
      stall_pct     = 14;
      send_random_text(150);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_go <= 1'b1;
      repeat (40) send_item(random_atom_byte(), 1'b0);
      send_item(CH_RPAREN, 1'b0);
      send_text("k");
      send_item(8'h00, 1'b1);
      wait_drained();
   endtask

   task automatic test_line_column();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_text("(q");
      repeat (20) send_item(CH_SPACE, 1'b0);
      send_text("w.(");
      repeat (4) send_item(CH_NL, 1'b0);
      send_text("\"s\" m)");
      send_item(8'h00, 1'b1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_go) begin
         hold_left <= RX_HOLD_CYCLES;
         hold_go   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      if (reset || hold_go || hold_left != 0)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : result_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = result_type'({rsp_tlast, rsp_tdata[44:0]});
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected: 0x%0h",
                                      result_count, rsp_tdata));
         end else begin
            want = pending_tokens.pop_front();
            check_field("event_res", 48'(seen.event_res), 48'(want.event_res));
            check_field("token_kind", 48'(seen.token_kind), 48'(want.token_kind));
            check_field("value_char", 48'(seen.value_char), 48'(want.value_char));
            check_field("line", 48'(seen.line), 48'(want.line));
            check_field("col", 48'(seen.col), 48'(want.col));
            check_field("last", 48'(seen.last), 48'(want.last));
            check_field("padding", 48'(rsp_tdata[47:45]), 48'(0));
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_tokens.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tokens();
      test_random_tokens();
      test_output_backpressure();
      test_line_column();
      if (pending_tokens.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_tokens.size()));
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sxt_pkg.sv
rtl/core/sxt_lexer.sv
rtl/core/sxt_out_buffer.sv
rtl/core/sexpr_tokenizer.sv
dv/testbench.sv
